// ----- rtl/bbp_pkg.sv -----
// Shared types and constants of the bimodal branch predictor.
`timescale 1ns / 1ps
package bbp_pkg;

  localparam int unsigned PC_BITS      = 64;
  localparam int unsigned CTR_ENTRIES  = 2048;
  localparam int unsigned CTR_IDX_BITS = $clog2(CTR_ENTRIES);

  typedef logic [1:0] ctr_t;

  localparam ctr_t CTR_MIN        = 2'd0;
  localparam ctr_t CTR_RESET      = 2'd1;
  localparam ctr_t CTR_WEAK_TAKEN = 2'd2;
  localparam ctr_t CTR_MAX        = 2'd3;

  localparam logic [PC_BITS-1:0] PC_STEP = 64'd4;

  typedef enum logic {
    REQ_PREDICT = 1'b0,
    REQ_UPDATE  = 1'b1
  } req_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CTR,
    ST_SCAN,
    ST_TGT,
    ST_RESP
  } bbp_state_e;

  typedef struct packed {
    req_e               req_type;
    logic [PC_BITS-1:0] pc;
    logic [PC_BITS-1:0] fall;
    logic [PC_BITS-1:0] target;
    logic               taken;
  } item_t;

  localparam int unsigned ITEM_BITS = $bits(item_t);

endpackage

// ----- rtl/bbp_fifo.sv -----
// Small first-in first-out queue of registers.
`timescale 1ns / 1ps
module bbp_fifo #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);
  localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);
  localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);

  logic [WIDTH-1:0]    mem_q [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic                do_push;
  logic                do_pop;

  assign full_o  = (cnt_q == CNT_FULL);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_BITS'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_BITS'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_BITS'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ----- rtl/bbp_front.sv -----
// Front stage: accepts request beats and classifies them as taken or not taken.
`timescale 1ns / 1ps
module bbp_front
  import bbp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic               hold_i,
  output logic               ready_o,
  input  logic               req_type_i,
  input  logic [PC_BITS-1:0] pc_i,
  input  logic [PC_BITS-1:0] actual_target_i,
  output item_t              item_o,
  output logic               item_vld_o,
  input  logic               item_full_i
);

  logic               vld_q, vld_d;
  item_t              item_q, item_d;
  logic               accept;
  logic [PC_BITS-1:0] fall;

  assign ready_o    = !hold_i && (!vld_q || !item_full_i);
  assign accept     = push_i && ready_o;
  assign fall       = pc_i + PC_STEP;
  assign item_o     = item_q;
  assign item_vld_o = vld_q;

  always_comb begin
    vld_d  = vld_q;
    item_d = item_q;
    if (accept) begin
      vld_d           = 1'b1;
      item_d.req_type = req_e'(req_type_i);
      item_d.pc       = pc_i;
      item_d.fall     = fall;
      item_d.target   = actual_target_i;
      item_d.taken    = (actual_target_i != fall);
    end else if (vld_q && !item_full_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

endmodule

// ----- rtl/bbp_back.sv -----
// Back engine: counter table, target buffer scan, training and prediction.
`timescale 1ns / 1ps
module bbp_back
  import bbp_pkg::*;
#(
  parameter int unsigned BTB_ENTRIES = 128,
  parameter int unsigned TAG_BITS    = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  item_t              item_i,
  input  logic               item_empty_i,
  output logic               item_pop_o,
  output logic [PC_BITS-1:0] res_o,
  output logic               res_push_o,
  input  logic               res_full_i,
  output logic               init_busy_o
);

  localparam int unsigned BTB_IDX_BITS = $clog2(BTB_ENTRIES);
  localparam logic [BTB_IDX_BITS-1:0] BTB_LAST = BTB_IDX_BITS'(BTB_ENTRIES - 1);
  localparam logic [CTR_IDX_BITS-1:0] CTR_LAST = CTR_IDX_BITS'(CTR_ENTRIES - 1);

  bbp_state_e state_q, state_d;
  item_t      cur_q, cur_d;

  logic [CTR_IDX_BITS-1:0] init_idx_q, init_idx_d;
  ctr_t                    cnt_mem [CTR_ENTRIES];
  ctr_t                    cnt_rdata_q;
  logic                    cnt_rd_en;
  logic [CTR_IDX_BITS-1:0] cnt_raddr;
  logic                    cnt_we;
  logic [CTR_IDX_BITS-1:0] cnt_waddr;
  ctr_t                    cnt_wdata;

  logic [TAG_BITS-1:0]     tag_mem [BTB_ENTRIES];
  logic [TAG_BITS-1:0]     tgt_mem [BTB_ENTRIES];
  logic [TAG_BITS-1:0]     tag_rdata_q;
  logic [TAG_BITS-1:0]     tgt_rdata_q;
  logic [BTB_IDX_BITS-1:0] tag_raddr;
  logic [BTB_IDX_BITS-1:0] scan_idx_q, scan_idx_d;
  logic [BTB_IDX_BITS-1:0] chk_idx_q;
  logic [BTB_IDX_BITS-1:0] rp_q, rp_d;
  logic                    tag_we;
  logic                    tgt_we;
  logic                    tgt_rd_en;
  logic [BTB_IDX_BITS-1:0] tgt_waddr;
  logic [TAG_BITS-1:0]     tgt_wdata;
  logic [BTB_ENTRIES-1:0]  btb_vld_q, btb_vld_d;

  logic [PC_BITS-1:0]      res_q, res_d;
  logic [TAG_BITS-1:0]     cur_tag;
  logic                    btb_hit;
  logic                    scan_end;
  logic                    ctr_taken;
  logic                    is_predict;

  assign cur_tag     = cur_q.pc[TAG_BITS-1:0];
  assign btb_hit     = btb_vld_q[chk_idx_q] && (tag_rdata_q == cur_tag);
  assign scan_end    = (chk_idx_q == BTB_LAST);
  assign ctr_taken   = (cnt_rdata_q >= CTR_WEAK_TAKEN);
  assign is_predict  = (cur_q.req_type == REQ_PREDICT);
  assign res_o       = res_q;
  assign init_busy_o = (state_q == ST_INIT);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: begin
        if (init_idx_q == CTR_LAST) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (!item_empty_i) state_d = ST_CTR;
      end
      ST_CTR: begin
        if (is_predict) begin
          state_d = ctr_taken ? ST_SCAN : ST_RESP;
        end else begin
          state_d = cur_q.taken ? ST_SCAN : ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (btb_hit) begin
          state_d = is_predict ? ST_TGT : ST_IDLE;
        end else if (scan_end) begin
          state_d = is_predict ? ST_RESP : ST_IDLE;
        end
      end
      ST_TGT: begin
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (!res_full_i) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    item_pop_o = 1'b0;
    res_push_o = 1'b0;
    cur_d      = cur_q;
    res_d      = res_q;
    init_idx_d = init_idx_q;
    cnt_rd_en  = 1'b0;
    cnt_raddr  = item_i.pc[CTR_IDX_BITS-1:0];
    cnt_we     = 1'b0;
    cnt_waddr  = cur_q.pc[CTR_IDX_BITS-1:0];
    cnt_wdata  = CTR_RESET;
    tag_raddr  = '0;
    scan_idx_d = scan_idx_q;
    tag_we     = 1'b0;
    tgt_we     = 1'b0;
    tgt_rd_en  = 1'b0;
    tgt_waddr  = chk_idx_q;
    tgt_wdata  = cur_q.target[TAG_BITS-1:0];
    rp_d       = rp_q;
    btb_vld_d  = btb_vld_q;
    unique case (state_q)
      ST_INIT: begin
        cnt_we     = 1'b1;
        cnt_waddr  = init_idx_q;
        init_idx_d = init_idx_q + CTR_IDX_BITS'(1);
      end
      ST_IDLE: begin
        if (!item_empty_i) begin
          item_pop_o = 1'b1;
          cnt_rd_en  = 1'b1;
          cur_d      = item_i;
        end
      end
      ST_CTR: begin
        scan_idx_d = BTB_IDX_BITS'(1);
        if (is_predict) begin
          res_d = cur_q.fall;
        end else begin
          cnt_we = 1'b1;
          if (cur_q.taken) begin
            cnt_wdata = (cnt_rdata_q == CTR_MAX) ? CTR_MAX : cnt_rdata_q + 2'd1;
          end else begin
            cnt_wdata = (cnt_rdata_q == CTR_MIN) ? CTR_MIN : cnt_rdata_q - 2'd1;
          end
        end
      end
      ST_SCAN: begin
        tag_raddr  = scan_idx_q;
        scan_idx_d = (scan_idx_q == BTB_LAST) ? '0 : scan_idx_q + BTB_IDX_BITS'(1);
        if (btb_hit) begin
          if (is_predict) begin
            tgt_rd_en = 1'b1;
          end else begin
            tgt_we = 1'b1;
          end
        end else if (scan_end) begin
          if (!is_predict) begin
            tag_we          = 1'b1;
            tgt_we          = 1'b1;
            tgt_waddr       = rp_q;
            btb_vld_d[rp_q] = 1'b1;
            rp_d            = (rp_q == BTB_LAST) ? '0 : rp_q + BTB_IDX_BITS'(1);
          end
        end
      end
      ST_TGT: begin
        res_d = {cur_q.pc[PC_BITS-1:TAG_BITS], tgt_rdata_q};
      end
      ST_RESP: begin
        res_push_o = 1'b1;
      end
      default: begin
        res_push_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_INIT;
      init_idx_q <= '0;
      rp_q       <= '0;
      btb_vld_q  <= '0;
    end else begin
      state_q    <= state_d;
      init_idx_q <= init_idx_d;
      rp_q       <= rp_d;
      btb_vld_q  <= btb_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    res_q      <= res_d;
    scan_idx_q <= scan_idx_d;
    chk_idx_q  <= tag_raddr;
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    if (cnt_rd_en) cnt_rdata_q <= cnt_mem[cnt_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (tag_we) tag_mem[rp_q] <= cur_tag;
    tag_rdata_q <= tag_mem[tag_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (tgt_we) tgt_mem[tgt_waddr] <= tgt_wdata;
    if (tgt_rd_en) tgt_rdata_q <= tgt_mem[chk_idx_q];
  end

  a_init_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_INIT |=> state_q != ST_INIT)
    else $error("counter clearing pass restarted");

  a_rp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rp_q <= BTB_LAST)
    else $error("replace pointer out of range");

  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> chk_idx_q <= BTB_LAST)
    else $error("scan index out of range");

  a_push_predict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> cur_q.req_type == REQ_PREDICT)
    else $error("result beat for an update request");

endmodule

// ----- rtl/bimodal_predictor_with_btb.sv -----
// Top level of the bimodal branch predictor with branch target buffer.
// After reset the block clears its 2048 counters, one per cycle, and holds full
// high while it does so. Each request beat passes a front register and a
// two-beat queue, then the back engine reads the counter. An update writes it
// back and, if not taken, ends there; a predict with a not-taken counter gives
// the fall-through address. A taken update or a predict with a taken counter
// scans the target buffer in order, one entry per cycle from entry 0 (tag
// memory read port); an update rewrites the hit or fills the replace slot on a
// miss, a predict hit reads its target. Results wait in a two-beat queue.
`timescale 1ns / 1ps
module bimodal_predictor_with_btb
  import bbp_pkg::*;
#(
  parameter int unsigned BTB_ENTRIES = 128,
  parameter int unsigned TAG_BITS    = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic               req_type_i,
  input  logic [PC_BITS-1:0] pc_i,
  input  logic [PC_BITS-1:0] actual_target_i,
  output logic               empty,
  input  logic               pop,
  output logic [PC_BITS-1:0] predicted_target_o
);

  logic               front_ready;
  item_t              front_item;
  logic               front_vld;
  logic               item_full;
  logic               item_empty;
  logic               item_pop;
  item_t              back_item;
  logic [PC_BITS-1:0] res;
  logic               res_push;
  logic               res_full;
  logic               init_busy;

  assign full = !front_ready;

  bbp_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .hold_i         (init_busy),
    .ready_o        (front_ready),
    .req_type_i     (req_type_i),
    .pc_i           (pc_i),
    .actual_target_i(actual_target_i),
    .item_o         (front_item),
    .item_vld_o     (front_vld),
    .item_full_i    (item_full)
  );

  bbp_fifo #(
    .WIDTH(ITEM_BITS),
    .DEPTH(2)
  ) u_item_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (front_vld),
    .wdata_i(front_item),
    .full_o (item_full),
    .pop_i  (item_pop),
    .rdata_o(back_item),
    .empty_o(item_empty)
  );

  bbp_back #(
    .BTB_ENTRIES(BTB_ENTRIES),
    .TAG_BITS   (TAG_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (back_item),
    .item_empty_i(item_empty),
    .item_pop_o  (item_pop),
    .res_o       (res),
    .res_push_o  (res_push),
    .res_full_i  (res_full),
    .init_busy_o (init_busy)
  );

  bbp_fifo #(
    .WIDTH(PC_BITS),
    .DEPTH(2)
  ) u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .wdata_i(res),
    .full_o (res_full),
    .pop_i  (pop),
    .rdata_o(predicted_target_o),
    .empty_o(empty)
  );

endmodule

// ----- bench/bimodal_predictor_with_btb_test.sv -----
// Self-checking testbench for the bimodal branch predictor with branch target buffer.
`timescale 1ns / 1ps
module bimodal_predictor_with_btb_test;
  import bbp_pkg::*;

  localparam int unsigned BTB_N        = 128;
  localparam int unsigned TAG_W        = 16;
  localparam int unsigned STALL_LIMIT  = 12000;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned POOL_N       = 32;
  localparam int unsigned IDLE_PCT     = 37;
  localparam int unsigned HOLD_CYCLES  = 400;

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               push = 1'b0;
  logic               full;
  logic               req_type_i = REQ_PREDICT;
  logic [PC_BITS-1:0] pc_i = '0;
  logic [PC_BITS-1:0] actual_target_i = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic [PC_BITS-1:0] predicted_target_o;

  bimodal_predictor_with_btb dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .push               (push),
    .full               (full),
    .req_type_i         (req_type_i),
    .pc_i               (pc_i),
    .actual_target_i    (actual_target_i),
    .empty              (empty),
    .pop                (pop),
    .predicted_target_o (predicted_target_o)
  );

  ctr_t               ctr_tbl   [CTR_ENTRIES];
  logic [TAG_W-1:0]   btb_tag_m [BTB_N];
  logic [TAG_W-1:0]   btb_tgt_m [BTB_N];
  logic               btb_vld_m [BTB_N];
  int unsigned        repl_ptr;
  logic [PC_BITS-1:0] target_q [$];
  logic [PC_BITS-1:0] branch_pool [POOL_N];
  logic [PC_BITS-1:0] want_target;

  int unsigned err_cnt, n_sent, n_checked, n_btb_hits, n_ptr_wraps, n_stall_cycles;
  int unsigned quiet_cyc;
  int unsigned rx_hold_req, rx_hold_left;
  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [PC_BITS-1:0] rand_dword();
    return {$urandom, $urandom};
  endfunction

  function automatic void clear_predictor();
    for (int i = 0; i < CTR_ENTRIES; i++) ctr_tbl[i] = CTR_RESET;
    for (int i = 0; i < BTB_N; i++) begin
      btb_tag_m[i] = '0;
      btb_tgt_m[i] = '0;
      btb_vld_m[i] = 1'b0;
    end
    repl_ptr = 0;
  endfunction

  function automatic int btb_find(logic [TAG_W-1:0] tag);
    for (int i = 0; i < BTB_N; i++) begin
      if (btb_vld_m[i] && btb_tag_m[i] == tag) return i;
    end
    return -1;
  endfunction

  function automatic void predict_and_train(req_e kind, logic [PC_BITS-1:0] pc,
                                            logic [PC_BITS-1:0] tgt);
    logic [PC_BITS-1:0]      fall;
    logic [CTR_IDX_BITS-1:0] idx;
    logic [TAG_W-1:0]        tag;
    int                      slot;
    fall = pc + PC_STEP;
    idx  = pc[CTR_IDX_BITS-1:0];
    tag  = pc[TAG_W-1:0];
    if (kind == REQ_PREDICT) begin
      slot = (ctr_tbl[idx] >= CTR_WEAK_TAKEN) ? btb_find(tag) : -1;
      if (slot >= 0) begin
        target_q.push_back({pc[PC_BITS-1:TAG_W], btb_tgt_m[slot]});
        n_btb_hits++;
      end else begin
        target_q.push_back(fall);
      end
    end else if (tgt == fall) begin
      if (ctr_tbl[idx] != CTR_MIN) ctr_tbl[idx] = ctr_tbl[idx] - 2'd1;
    end else begin
      if (ctr_tbl[idx] != CTR_MAX) ctr_tbl[idx] = ctr_tbl[idx] + 2'd1;
      slot = btb_find(tag);
      if (slot < 0) begin
        slot = repl_ptr;
        btb_tag_m[slot] = tag;
        btb_vld_m[slot] = 1'b1;
        repl_ptr = (repl_ptr + 1) % BTB_N;
        if (repl_ptr == 0) n_ptr_wraps++;
      end
      btb_tgt_m[slot] = tgt[TAG_W-1:0];
    end
  endfunction

  function automatic void refill_pool();
    for (int i = 0; i < POOL_N; i++) branch_pool[i] = rand_dword();
  endfunction

  // mostly reuse hot branches so counters saturate and the buffer hits
  function automatic logic [PC_BITS-1:0] pick_pc();
    logic [PC_BITS-1:0] base;
    logic [PC_BITS-1:0] r;
    int unsigned        roll;
    base = branch_pool[$urandom_range(POOL_N-1)];
    r    = rand_dword();
    roll = $urandom_range(99);
    if (roll < 65) return base;
    if (roll < 75) return {r[PC_BITS-1:TAG_W], base[TAG_W-1:0]};
    if (roll < 80) return base ^ (PC_BITS'($urandom_range(31, 1)) << CTR_IDX_BITS);
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    err_cnt++;
  endtask

  task automatic send_beat(req_e kind, logic [PC_BITS-1:0] pc, logic [PC_BITS-1:0] tgt);
    while (tx_idle_on && $urandom_range(99) < IDLE_PCT) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push            <= 1'b1;
    req_type_i      <= kind;
    pc_i            <= pc;
    actual_target_i <= tgt;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    predict_and_train(kind, pc, tgt);
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic tx_stop();
    push <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic wait_results_drained();
    while (target_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic send_random_beat(int unsigned predict_pct);
    logic [PC_BITS-1:0] pc;
    pc = pick_pc();
    if ($urandom_range(99) < predict_pct) send_beat(REQ_PREDICT, pc, rand_dword());
    else if ($urandom_range(99) < 35) send_beat(REQ_UPDATE, pc, pc + PC_STEP);
    else send_beat(REQ_UPDATE, pc, rand_dword());
  endtask

  task automatic test_directed();
    logic [PC_BITS-1:0] hot;
    logic [PC_BITS-1:0] ones;
    hot  = 64'h0000_1234_5678_9ab0;
    ones = '1;
    send_beat(REQ_PREDICT, '0, '0);
    send_beat(REQ_PREDICT, ones, '0);
    send_beat(REQ_UPDATE, '0, PC_STEP);
    send_beat(REQ_UPDATE, '0, PC_STEP);
    send_beat(REQ_PREDICT, '0, ones);
    send_beat(REQ_UPDATE, hot, 64'h0000_0000_0000_4444);
    send_beat(REQ_PREDICT, hot, '0);
    send_beat(REQ_UPDATE, hot, ones);
    send_beat(REQ_UPDATE, hot, 64'hdead_0000_0000_1110);
    send_beat(REQ_PREDICT, hot, '0);
    send_beat(REQ_PREDICT, {16'hbeef, 32'h0, hot[TAG_W-1:0]}, '0);
    send_beat(REQ_PREDICT, hot ^ 64'h800, '0);
    send_beat(REQ_UPDATE, hot, hot + PC_STEP);
    send_beat(REQ_PREDICT, hot, '0);
    send_beat(REQ_UPDATE, ones - 64'd3, '0);
    send_beat(REQ_UPDATE, ones, ones);
    send_beat(REQ_PREDICT, ones, '0);
    send_beat(REQ_UPDATE, '0, ones);
    send_beat(REQ_PREDICT, '0, '0);
    tx_stop();
    wait_results_drained();
  endtask

  task automatic test_random(int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 250 == 0) refill_pool();
      send_random_beat(45);
    end
    tx_stop();
  endtask

  task automatic test_no_idle(int unsigned n);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    for (int unsigned i = 0; i < n; i++) send_random_beat(50);
    tx_stop();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  task automatic test_backpressure();
    rx_hold_req = HOLD_CYCLES;
    repeat (40) send_beat(REQ_PREDICT, rand_dword(), rand_dword());
    tx_stop();
  endtask

  task automatic test_drain_pause();
    wait_results_drained();
    repeat (30) send_random_beat(45);
    tx_stop();
  endtask

  always @(negedge clk_i) begin
    if (rx_hold_req != 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req  = 0;
    end
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      pop <= 1'b0;
    end else if (rx_idle_on && $urandom_range(99) < IDLE_PCT) begin
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (target_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result beat %h", predicted_target_o));
      end else begin
        want_target = target_q.pop_front();
        n_checked++;
        if (predicted_target_o !== want_target)
          report_mismatch($sformatf("predicted_target %h, want %h",
                                    predicted_target_o, want_target));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && full) n_stall_cycles++;
      if ((push && !full) || (pop && !empty)) quiet_cyc = 0;
      else quiet_cyc++;
      if (quiet_cyc >= STALL_LIMIT) begin
        $display("watchdog: no beat moved for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, target_q.size());
        $display("bimodal_predictor_with_btb verification failed");
        $finish;
      end
    end
  end

  initial begin
    clear_predictor();
    refill_pool();
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random(500);
    test_backpressure();
    test_drain_pause();
    test_no_idle(250);
    test_random(420);
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    $display("covered %0d requests, %0d predictions checked, %0d from buffer hits",
             n_sent, n_checked, n_btb_hits);
    $display("replacement pointer wrapped %0d times, input stalled %0d cycles",
             n_ptr_wraps, n_stall_cycles);
    if (err_cnt == 0) begin
      $display("bimodal_predictor_with_btb verification clean");
    end else begin
      $display("bimodal_predictor_with_btb verification failed");
    end
    $finish;
  end

endmodule

// ----- bimodal_predictor_with_btb.f -----
rtl/bbp_pkg.sv
rtl/bbp_fifo.sv
rtl/bbp_front.sv
rtl/bbp_back.sv
rtl/bimodal_predictor_with_btb.sv
bench/bimodal_predictor_with_btb_test.sv
